### hdl/srp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srp_pkg
// Types and constants shared by the skyline packer cells and the top level.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam logic [12:0] MAX_SIDE   = 13'd4096;
  localparam logic [12:0] SIDE_MIN   = 13'd3;
  localparam logic [12:0] SIDE_RESET = 13'd512;
  localparam logic [24:0] AREA_MAX   = 25'h1FFFFFF;

  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_NOROOM = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [1:0] REG_ATLAS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_ATLAS_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INIT,
    OP_ROT,
    OP_ACC,
    OP_INSERT,
    OP_ERASE,
    OP_CUT
  } op_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] top;
    logic [11:0] width;
  } seg_t;

  typedef struct packed {
    logic               act;
    logic               ok;
    logic [11:0]        y;
    logic signed [13:0] left;
    logic [11:0]        bw;
    logic [11:0]        bx;
  } acc_t;

  typedef struct packed {
    op_t         op;
    logic        absorb;
    logic [12:0] rw;
    logic [12:0] rh;
    logic [11:0] aw_m1;
    logic [11:0] ah_m1;
    logic [11:0] edge_x;
    seg_t        nseg;
  } cmd_t;

  typedef struct packed {
    logic er;
    logic tr;
    logic ma;
    logic mb;
  } flag_t;

  function automatic logic [12:0] clamp_side(input logic [12:0] v);
    logic [12:0] r;
    r = v;
    if (v < SIDE_MIN) r = SIDE_MIN;
    else if (v > MAX_SIDE) r = MAX_SIDE;
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/srp_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srp_cell
// One skyline segment slot with its candidate fit accumulator.
// ----------------------------------------------------------------------------
module srp_cell #(
  parameter int N   = 256,
  parameter int IDX = 0
) (
  input  wire logic                  clk,
  input  wire srp_pkg::cmd_t         cmd,
  input  wire logic [$clog2(N)-1:0]  k,
  input  wire logic [$clog2(N)-1:0]  best,
  input  wire logic [$clog2(N)-1:0]  e,
  input  wire logic [$clog2(N+1)-1:0] count,
  input  wire srp_pkg::seg_t         prev_seg,
  input  wire srp_pkg::seg_t         next_seg,
  input  wire srp_pkg::acc_t         next_acc,
  output srp_pkg::seg_t              seg,
  output srp_pkg::acc_t              acc,
  output srp_pkg::flag_t             flg
);
  import srp_pkg::*;

  localparam int IW = $clog2(N);
  localparam int XW = IW + 1;
  localparam logic [XW-1:0] MY_I = XW'(IDX);

  seg_t seg_next;
  acc_t acc_next;
  logic [XW-1:0] cnt;
  logic [XW-1:0] pos;
  logic [XW-1:0] best1;
  logic [13:0] xr;
  logic [13:0] yh;
  logic [11:0] ymax;
  logic [12:0] seg_end;
  logic signed [13:0] lnew;

  assign cnt   = XW'(count);
  assign pos   = MY_I + XW'(k);
  assign best1 = XW'(best) + XW'(1);
  assign seg_end = {1'b0, seg.x} + {1'b0, seg.width};

  always_comb begin
    flg.er = 1'b0;
    flg.tr = 1'b0;
    if (MY_I == best1 && MY_I < cnt && seg.x < cmd.edge_x) begin
      if (seg_end <= {1'b0, cmd.edge_x}) flg.er = 1'b1;
      else flg.tr = 1'b1;
    end
    flg.ma = (MY_I == XW'(best)) && (MY_I + XW'(1) < cnt) && (seg.top == next_seg.top);
    flg.mb = (MY_I + XW'(1) == XW'(best)) && (seg.top == next_seg.top);
  end

  always_comb begin
    seg_next = seg;
    acc_next = acc;
    xr   = {2'b0, seg.x} + {1'b0, cmd.rw};
    ymax = (seg.top > acc.y) ? seg.top : acc.y;
    yh   = 14'd0;
    lnew = 14'sd0;
    case (cmd.op)
      OP_INIT: begin
        if (IDX == 0) seg_next = cmd.nseg;
      end
      OP_ROT: begin
        seg_next = next_seg;
        if (k == '0) begin
          acc_next.act = 1'b0;
          acc_next.ok  = 1'b0;
          acc_next.bw  = seg.width;
          acc_next.bx  = seg.x;
          acc_next.y   = seg.top;
          yh   = {2'b0, seg.top} + {1'b0, cmd.rh};
          lnew = $signed({1'b0, cmd.rw}) - $signed({2'b0, seg.width});
          acc_next.left = lnew;
          if (MY_I < cnt && xr <= {2'b0, cmd.aw_m1} && yh <= {2'b0, cmd.ah_m1}) begin
            if (lnew <= 14'sd0) acc_next.ok = 1'b1;
            else acc_next.act = 1'b1;
          end
        end else if (acc.act) begin
          yh   = {2'b0, ymax} + {1'b0, cmd.rh};
          lnew = acc.left - $signed({2'b0, seg.width});
          if (pos >= cnt || yh > {2'b0, cmd.ah_m1}) begin
            acc_next.act = 1'b0;
          end else begin
            acc_next.y    = ymax;
            acc_next.left = lnew;
            if (lnew <= 14'sd0) begin
              acc_next.act = 1'b0;
              acc_next.ok  = 1'b1;
            end
          end
        end
      end
      OP_ACC: begin
        acc_next = next_acc;
      end
      OP_INSERT: begin
        if (MY_I == XW'(best)) seg_next = cmd.nseg;
        else if (MY_I > XW'(best)) seg_next = prev_seg;
      end
      OP_ERASE: begin
        if (MY_I >= XW'(e)) seg_next = next_seg;
        else if (cmd.absorb && MY_I + XW'(1) == XW'(e))
          seg_next.width = seg.width + next_seg.width;
      end
      OP_CUT: begin
        if (flg.tr) begin
          seg_next.x     = cmd.edge_x;
          seg_next.width = 12'(seg_end - {1'b0, cmd.edge_x});
        end
      end
      default: begin
        seg_next = seg;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    seg <= seg_next;
    acc <= acc_next;
  end

endmodule
`default_nettype wire

### hdl/skyline_rect_packer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skyline_rect_packer
// Skyline bottom-left rectangle packer built as a ring of segment cells.
//
//   channel  signals                                          direction
//   in       in_valid/in_ready, rect_width, rect_height       to block
//   out      out_valid/out_ready, status, place_x, place_y,   from block
//            used_area
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data         to block
//
// A request walks one full rotation of the segment ring for the fit walk,
// then one pass shifting candidates to the head for selection, then insert,
// trim (one step per covered segment) and merges.
// Reset and every size write pass an init step that loads the first segment.
// A waiting result sits in the output register; the next transaction is
// taken meanwhile and holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module skyline_rect_packer #(
  parameter int MAX_SEGMENTS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [12:0] rect_width,
  input  wire logic [12:0] rect_height,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [11:0]      place_x,
  output logic [11:0]      place_y,
  output logic [24:0]      used_area,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);
  import srp_pkg::*;

  localparam int N  = MAX_SEGMENTS;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_FIT, S_SEL, S_DECIDE, S_INSERT, S_TRIM, S_MA, S_MB, S_AREA, S_DONE
  } state_t;

  state_t        state;
  logic [IW-1:0] k;
  logic [IW-1:0] best;
  logic [IW-1:0] e;
  logic [CW-1:0] seg_count;
  logic          found;
  logic [12:0]   best_bot;
  logic [11:0]   best_w;
  logic [11:0]   bx;
  logic [11:0]   by;
  logic [12:0]   rw;
  logic [12:0]   rh;
  logic [25:0]   prod;
  logic [24:0]   area;
  logic [12:0]   aw;
  logic [12:0]   ah;
  logic [1:0]    res;
  cmd_t          cmd;
  flag_t         fl;
  logic [12:0]   bot;
  logic [26:0]   asum;

  seg_t  seg_q [N];
  acc_t  acc_q [N];
  flag_t flg_q [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    srp_cell #(.N(N), .IDX(i)) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .k        (k),
      .best     (best),
      .e        (e),
      .count    (seg_count),
      .prev_seg ((i == 0) ? seg_t'('0) : seg_q[(i == 0) ? 0 : i - 1]),
      .next_seg (seg_q[(i + 1) % N]),
      .next_acc ((i == N - 1) ? acc_t'('0) : acc_q[(i + 1) % N]),
      .seg      (seg_q[i]),
      .acc      (acc_q[i]),
      .flg      (flg_q[i])
    );
  end

  always_comb begin
    fl = '0;
    for (int i = 0; i < N; i++) fl = fl | flg_q[i];
  end

  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign bot  = {1'b0, acc_q[0].y} + rh;
  assign asum = {2'b0, area} + {1'b0, prod};

  always_comb begin
    cmd        = '0;
    cmd.op     = OP_HOLD;
    cmd.rw     = rw;
    cmd.rh     = rh;
    cmd.aw_m1  = 12'(aw - 13'd1);
    cmd.ah_m1  = 12'(ah - 13'd1);
    cmd.edge_x = bx + rw[11:0];
    cmd.nseg   = '{x: bx, top: by + rh[11:0], width: rw[11:0]};
    e          = IW'(best + IW'(1));
    unique case (state)
      S_INIT: begin
        cmd.op   = OP_INIT;
        cmd.nseg = '{x: 12'd1, top: 12'd1, width: 12'(aw - 13'd2)};
      end
      S_FIT:    cmd.op = OP_ROT;
      S_SEL:    cmd.op = OP_ACC;
      S_INSERT: cmd.op = OP_INSERT;
      S_TRIM: begin
        if (fl.er) cmd.op = OP_ERASE;
        else if (fl.tr) cmd.op = OP_CUT;
      end
      S_MA: begin
        cmd.absorb = 1'b1;
        if (fl.ma) cmd.op = OP_ERASE;
      end
      S_MB: begin
        cmd.absorb = 1'b1;
        e = best;
        if (fl.mb) cmd.op = OP_ERASE;
      end
      default: cmd.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      aw        <= SIDE_RESET;
      ah        <= SIDE_RESET;
      seg_count <= CW'(1);
      area      <= '0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_INIT: begin
          seg_count <= CW'(1);
          area      <= '0;
          state     <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == REG_ATLAS_WIDTH) begin
              aw    <= clamp_side(cfg_data);
              state <= S_INIT;
            end else if (cfg_index == REG_ATLAS_HEIGHT) begin
              ah    <= clamp_side(cfg_data);
              state <= S_INIT;
            end
          end else if (in_valid) begin
            rw    <= rect_width;
            rh    <= rect_height;
            prod  <= rect_width * rect_height;
            found <= 1'b0;
            k     <= '0;
            if (rect_width == '0 || rect_height == '0) begin
              res   <= ST_NOROOM;
              state <= S_DONE;
            end else begin
              state <= S_FIT;
            end
          end
        end
        S_FIT: begin
          if (k == IW'(N - 1)) begin
            k     <= '0;
            state <= S_SEL;
          end else begin
            k <= IW'(k + IW'(1));
          end
        end
        S_SEL: begin
          if (acc_q[0].ok && (!found || bot < best_bot ||
              (bot == best_bot && acc_q[0].bw < best_w))) begin
            found    <= 1'b1;
            best     <= k;
            best_bot <= bot;
            best_w   <= acc_q[0].bw;
            bx       <= acc_q[0].bx;
            by       <= acc_q[0].y;
          end
          if (k == IW'(N - 1)) begin
            k     <= '0;
            state <= S_DECIDE;
          end else begin
            k <= IW'(k + IW'(1));
          end
        end
        S_DECIDE: begin
          if (!found) begin
            res   <= ST_NOROOM;
            state <= S_DONE;
          end else if (seg_count == CW'(N)) begin
            res   <= ST_FULL;
            state <= S_DONE;
          end else begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          seg_count <= seg_count + CW'(1);
          state     <= S_TRIM;
        end
        S_TRIM: begin
          if (fl.er) seg_count <= seg_count - CW'(1);
          else state <= S_MA;
        end
        S_MA: begin
          if (fl.ma) seg_count <= seg_count - CW'(1);
          state <= S_MB;
        end
        S_MB: begin
          if (fl.mb) seg_count <= seg_count - CW'(1);
          state <= S_AREA;
        end
        S_AREA: begin
          area  <= (asum > {2'b0, AREA_MAX}) ? AREA_MAX : asum[24:0];
          res   <= ST_PLACED;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= res;
            place_x   <= (res == ST_PLACED) ? bx : 12'd0;
            place_y   <= (res == ST_PLACED) ? by : 12'd0;
            used_area <= area;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    seg_count <= CW'(N) && seg_count != '0) else $error("segment count out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE) else $error("idle right after accept");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    state == S_INSERT |-> seg_count < CW'(N)) else $error("insert into full table");

  a_placed_area: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_PLACED |-> used_area != '0 && place_x != '0)
    else $error("placed result without area");

endmodule
`default_nettype wire
